// File: src/nlq_pkg.sv
// Shared types, codes and helpers for the neighbor link quality tracker.
// Used by nlq_cell and neighbor_link_quality_tracker_top; depends on nothing.
package nlq_pkg;

  // Fixed field widths of the block's payload.
  localparam int MacW   = 48;
  localparam int SeqW   = 16;
  localparam int SlotW  = 4;
  localparam int CountW = 6;
  localparam int ThW    = 6;
  localparam int CfgW   = 16;
  localparam int CfgAW  = 2;

  // Widest reception window any cell supports.
  localparam int WinMaxBits = 64;

  // Configuration register indexes.
  localparam logic [CfgAW-1:0] CFG_MAX_SEQ = 2'd0;
  localparam logic [CfgAW-1:0] CFG_UP_TH   = 2'd1;
  localparam logic [CfgAW-1:0] CFG_DOWN_TH = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [SeqW-1:0] MaxSeqReset = 16'd10000;
  localparam logic [ThW-1:0]  UpThReset   = 6'd12;
  localparam logic [ThW-1:0]  DownThReset = 6'd4;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_UP   = 3'd1,
    EV_DOWN = 3'd2,
    EV_FULL = 3'd3,
    EV_SEQ  = 3'd4
  } event_t;

  // Receive transaction fields broadcast to every cell.
  typedef struct packed {
    logic [MacW-1:0] mac;
    logic [SeqW-1:0] seq;
    logic            lists_me;
  } query_t;

  // Configuration broadcast to every cell.
  typedef struct packed {
    logic [SeqW-1:0] max_seq;
    logic [ThW-1:0]  up_th;
    logic [ThW-1:0]  down_th;
  } cfg_t;

  // Token handed from cell to cell. The scan pass gathers hit and free flags;
  // the update pass carries the hit flag in and the selected cell's result out.
  typedef struct packed {
    logic              act;
    logic              pass_b;
    logic              hit;
    logic              free;
    event_t            ev;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
  } token_t;

  // Population count of a 64-bit word as a balanced adder tree.
  function automatic logic [6:0] popcount64(input logic [WinMaxBits-1:0] v);
    logic [1:0] s1 [32];
    logic [2:0] s2 [16];
    logic [3:0] s3 [8];
    logic [4:0] s4 [4];
    logic [5:0] s5 [2];
    for (int i = 0; i < 32; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    return {1'b0, s5[0]} + {1'b0, s5[1]};
  endfunction

endpackage

// File: src/neighbor_link_quality_tracker_top.sv
// Neighbor link quality tracker: a sequencer driving a chain of table cells.
// A send transaction goes from acceptance straight to the finish state and the output register.
// A receive transaction takes a scan pass and an update pass along the cell chain before its result
// reaches the output (only the scan pass when the table is full and holds no entry for the address);
// one item is in work at a time, and a result still waiting at the output holds the finish state.
// Synchronous reset clears the valid bits, the sequencer state, the configuration and the tokens.
module neighbor_link_quality_tracker_top #(
  parameter int TABLE_ENTRIES = 16,
  parameter int WINDOW_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [47:0] src_mac,
  input  logic [15:0] seq,
  input  logic        lists_me,
  // Output channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [47:0] neighbor_mac,
  output logic [3:0]  slot,
  output logic [5:0]  link_count,
  output logic [15:0] seq_out
);
  import nlq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  state_t state;

  cfg_t            cfg;
  query_t          q;
  logic [SeqW-1:0] send_counter;
  logic [SeqW:0]   send_inc;
  token_t          head_tok;
  token_t          chain [TABLE_ENTRIES+1];
  token_t          tail;

  // Result waiting for the output register.
  event_t            pend_ev;
  logic [MacW-1:0]   pend_mac;
  logic [SlotW-1:0]  pend_slot;
  logic [CountW-1:0] pend_count;
  logic [SeqW-1:0]   pend_seq;
  event_t            out_ev;

  assign in_ready  = (state == ST_IDLE);
  assign event_res = out_ev;
  assign send_inc  = {1'b0, send_counter} + 17'd1;
  assign chain[0]  = head_tok;
  assign tail      = chain[TABLE_ENTRIES];

  // Chain of table cells; the token steps one cell each cycle.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    nlq_cell #(
      .INDEX       (i),
      .WINDOW_BITS (WINDOW_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .q       (q),
      .cfg     (cfg),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_seq <= MaxSeqReset;
      cfg.up_th   <= UpThReset;
      cfg.down_th <= DownThReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_SEQ: cfg.max_seq <= cfg_wdata;
        CFG_UP_TH:   cfg.up_th   <= cfg_wdata[ThW-1:0];
        CFG_DOWN_TH: cfg.down_th <= cfg_wdata[ThW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: accept, scan pass, update pass, hand the result to the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      send_counter <= '0;
      head_tok     <= '0;
      out_valid    <= 1'b0;
    end else begin
      // The head token is live for one cycle at the start of each pass.
      head_tok.act <= ((state == ST_IDLE) && in_valid && cmd) ||
                      ((state == ST_SCAN) && tail.act && (tail.hit || tail.free));
      // The output holds its transaction until it is taken.
      if ((state == ST_FINISH) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            q.mac      <= src_mac;
            q.seq      <= seq;
            q.lists_me <= lists_me;
            if (!cmd) begin
              pend_ev    <= EV_SEQ;
              pend_mac   <= '0;
              pend_slot  <= '0;
              pend_count <= '0;
              pend_seq   <= send_counter;
              if (send_inc >= {1'b0, cfg.max_seq}) begin
                send_counter <= '0;
              end else begin
                send_counter <= send_inc[SeqW-1:0];
              end
              state <= ST_FINISH;
            end else begin
              head_tok.pass_b <= 1'b0;
              head_tok.hit    <= 1'b0;
              state           <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (tail.act) begin
            if (!tail.hit && !tail.free) begin
              pend_ev    <= EV_FULL;
              pend_mac   <= q.mac;
              pend_slot  <= '0;
              pend_count <= '0;
              pend_seq   <= '0;
              state      <= ST_FINISH;
            end else begin
              head_tok.pass_b <= 1'b1;
              head_tok.hit    <= tail.hit;
              state           <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          if (tail.act) begin
            pend_ev    <= tail.ev;
            pend_mac   <= q.mac;
            pend_slot  <= tail.slot;
            pend_count <= tail.count;
            pend_seq   <= '0;
            state      <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_ev       <= pend_ev;
            neighbor_mac <= pend_mac;
            slot         <= pend_slot;
            link_count   <= pend_count;
            seq_out      <= pend_seq;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/nlq_cell.sv
// One neighbor table entry of the tracker chain, with its own window update.
// Depends on nlq_pkg for the token, query and configuration types.
module nlq_cell #(
  parameter int INDEX       = 0,
  parameter int WINDOW_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  nlq_pkg::query_t q,
  input  nlq_pkg::cfg_t   cfg,
  input  nlq_pkg::token_t tok_in,
  output nlq_pkg::token_t tok_out
);
  import nlq_pkg::*;

  localparam int ShW = $clog2(WINDOW_BITS);

  // Entry state.
  logic                   valid;
  logic [MacW-1:0]        mac;
  logic [WINDOW_BITS-1:0] win;
  logic [SeqW-1:0]        last;
  logic                   up;

  // Outcome of the last scan pass for this cell.
  logic first_hit;
  logic first_free;

  logic                   match;
  logic                   sel;
  logic                   scan_en;
  logic                   upd_en;
  logic [WINDOW_BITS-1:0] base_win;
  logic [SeqW-1:0]        base_last;
  logic                   base_up;
  logic [17:0]            gap;
  logic                   big_gap;
  logic [WINDOW_BITS-1:0] win_next;
  logic [6:0]             cnt;
  logic                   up_next;
  event_t                 ev;
  token_t                 tok_next;

  assign match   = valid && (mac == q.mac);
  assign scan_en = tok_in.act && !tok_in.pass_b;
  assign sel     = tok_in.hit ? first_hit : first_free;
  assign upd_en  = tok_in.act && tok_in.pass_b && sel;

  // A freshly allocated entry starts empty with its last sequence equal to this one.
  assign base_win  = tok_in.hit ? win  : '0;
  assign base_last = tok_in.hit ? last : q.seq;
  assign base_up   = tok_in.hit ? up   : 1'b0;

  // Wrapped sequence gap; a negative wrapped value counts as a huge gap.
  always_comb begin
    if (q.seq >= base_last) begin
      gap = {2'b00, q.seq} - {2'b00, base_last};
    end else begin
      gap = {2'b00, cfg.max_seq} + {2'b00, q.seq} - {2'b00, base_last};
    end
  end

  assign big_gap = gap[17] || (gap[16:0] >= 17'(WINDOW_BITS));

  // Shift the window by the gap, mark this reception and count it.
  always_comb begin
    if (big_gap) begin
      win_next = '0;
    end else begin
      win_next = base_win << gap[ShW-1:0];
    end
    win_next[0] = 1'b1;
  end

  assign cnt = popcount64(WinMaxBits'(win_next));

  // Hysteresis between the reported up and down conditions.
  always_comb begin
    ev      = EV_NONE;
    up_next = base_up;
    if (!base_up && (cnt > {1'b0, cfg.up_th}) && q.lists_me) begin
      ev      = EV_UP;
      up_next = 1'b1;
    end else if (base_up && ((cnt < {1'b0, cfg.down_th}) || !q.lists_me)) begin
      ev      = EV_DOWN;
      up_next = 1'b0;
    end
  end

  // Token for the next cell.
  always_comb begin
    tok_next = tok_in;
    if (scan_en) begin
      tok_next.hit  = tok_in.hit | match;
      tok_next.free = tok_in.free | !valid;
    end
    if (upd_en) begin
      tok_next.ev    = ev;
      tok_next.slot  = SlotW'(INDEX);
      tok_next.count = cnt[CountW-1:0];
    end
  end

  // Control state and the token register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      first_hit  <= 1'b0;
      first_free <= 1'b0;
      tok_out    <= '0;
    end else begin
      tok_out <= tok_next;
      if (scan_en) begin
        first_hit  <= match && !tok_in.hit;
        first_free <= !valid && !tok_in.free;
      end
      if (upd_en) begin
        valid <= 1'b1;
      end
    end
  end

  // Entry payload, written by the update pass when this cell is selected.
  always_ff @(posedge clk) begin
    if (upd_en) begin
      mac  <= q.mac;
      win  <= win_next;
      last <= q.seq;
      up   <= up_next;
    end
  end

endmodule
